// File: sv/ascs_pkg.sv
// ----------------------------------------------------------------------------
// ascs_pkg
// Shared types and codes of the two-register stack processor step block.
// ----------------------------------------------------------------------------
`default_nettype none

package ascs_pkg;

  localparam int unsigned MEM_WORDS_DEF = 4096;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned FADDR_W   = 12;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned OPC_W     = 8;
  localparam int unsigned OPND_W    = 24;
  localparam int unsigned SHIFT_LIM = 32;
  localparam int unsigned SHAMT_W   = $clog2(SHIFT_LIM);

  typedef logic [WORD_W-1:0] word_t;

  // Item commands
  localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_EXEC = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

  // Run status codes
  localparam logic [STAT_W-1:0] STAT_RUN   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_HALT  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BADOP = 2'd2;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd3;

  // Opcodes
  localparam logic [OPC_W-1:0] OP_LDC  = 8'd0;
  localparam logic [OPC_W-1:0] OP_ADC  = 8'd1;
  localparam logic [OPC_W-1:0] OP_LDL  = 8'd2;
  localparam logic [OPC_W-1:0] OP_STL  = 8'd3;
  localparam logic [OPC_W-1:0] OP_LDNL = 8'd4;
  localparam logic [OPC_W-1:0] OP_STNL = 8'd5;
  localparam logic [OPC_W-1:0] OP_ADD  = 8'd6;
  localparam logic [OPC_W-1:0] OP_SUB  = 8'd7;
  localparam logic [OPC_W-1:0] OP_SHL  = 8'd8;
  localparam logic [OPC_W-1:0] OP_SHR  = 8'd9;
  localparam logic [OPC_W-1:0] OP_ADJ  = 8'd10;
  localparam logic [OPC_W-1:0] OP_A2SP = 8'd11;
  localparam logic [OPC_W-1:0] OP_SP2A = 8'd12;
  localparam logic [OPC_W-1:0] OP_CALL = 8'd13;
  localparam logic [OPC_W-1:0] OP_RET  = 8'd14;
  localparam logic [OPC_W-1:0] OP_BRZ  = 8'd15;
  localparam logic [OPC_W-1:0] OP_BRLZ = 8'd16;
  localparam logic [OPC_W-1:0] OP_BR   = 8'd17;
  localparam logic [OPC_W-1:0] OP_HALT = 8'd18;

endpackage

`default_nettype wire

// File: sv/ascs_if.sv
// ----------------------------------------------------------------------------
// ascs_in_if / ascs_out_if
// Valid/ready channels for command items and step results.
// ----------------------------------------------------------------------------
`default_nettype none

interface ascs_in_if;
  logic                             valid;
  logic                             ready;
  logic [ascs_pkg::CMD_W-1:0]       cmd;
  logic [ascs_pkg::FADDR_W-1:0]     address;
  logic [ascs_pkg::WORD_W-1:0]      data;

  modport source (output valid, output cmd, output address, output data, input ready);
  modport sink   (input valid, input cmd, input address, input data, output ready);
endinterface

interface ascs_out_if;
  logic                             valid;
  logic                             ready;
  logic [ascs_pkg::WORD_W-1:0]      reg_a;
  logic [ascs_pkg::WORD_W-1:0]      reg_b;
  logic signed [ascs_pkg::WORD_W-1:0] prog_counter;
  logic signed [ascs_pkg::WORD_W-1:0] stack_ptr;
  logic [ascs_pkg::STAT_W-1:0]      run_status;
  logic [ascs_pkg::WORD_W-1:0]      read_word;

  modport source (output valid, output reg_a, output reg_b, output prog_counter,
                  output stack_ptr, output run_status, output read_word, input ready);
  modport sink   (input valid, input reg_a, input reg_b, input prog_counter,
                  input stack_ptr, input run_status, input read_word, output ready);
endinterface

`default_nettype wire

// File: sv/ascs_ram.sv
// ----------------------------------------------------------------------------
// ascs_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ascs_ram #(
  parameter int unsigned WIDTH = ascs_pkg::WORD_W,
  parameter int unsigned DEPTH = ascs_pkg::MEM_WORDS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// File: sv/accumulator_stack_cpu_step.sv
// ----------------------------------------------------------------------------
// accumulator_stack_cpu_step
// Two-register stack processor that loads, executes or reads one item a step.
// ----------------------------------------------------------------------------
// After reset the block sweeps its word memory to zero, one word a cycle, so
// in_ch.ready stays low until the sweep ends, before the first transaction.
// Every item then returns exactly one result transaction carrying A, B, PC,
// SP, the run status and, for a read, the memory word. All memory traffic
// shares the one port of the word RAM, which sets the steps of each item: a
// load writes and retires, a read reads and retires, an executed instruction
// fetches, then retires, and ldl/ldnl fetch, read data, then retire. A stopped
// processor or a bad fetch address retires without a fetch. A new transaction
// is taken while a finished result still waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module accumulator_stack_cpu_step #(
  parameter int unsigned MEM_WORDS = ascs_pkg::MEM_WORDS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  ascs_in_if.sink       in_ch,
  ascs_out_if.source    out_ch
);

  localparam int unsigned AW = $clog2(MEM_WORDS);
  localparam logic [ascs_pkg::WORD_W-1:0] MEM_LIMIT  = ascs_pkg::WORD_W'(MEM_WORDS);
  localparam logic [AW-1:0]               LAST_ENTRY = AW'(MEM_WORDS - 1);
  localparam int unsigned EXT_W = ascs_pkg::WORD_W - ascs_pkg::FADDR_W;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_FETCH,
    S_DATA,
    S_DONE
  } state_t;

  state_t                         state_r, state_nxt;
  ascs_pkg::word_t                a_r, a_nxt;
  ascs_pkg::word_t                b_r, b_nxt;
  ascs_pkg::word_t                pc_r, pc_nxt;
  ascs_pkg::word_t                sp_r, sp_nxt;
  logic [ascs_pkg::STAT_W-1:0]    stat_r, stat_nxt;
  ascs_pkg::word_t                rd_r, rd_nxt;
  logic                           ldl_r, ldl_nxt;
  logic [AW-1:0]                  clr_r, clr_nxt;

  // Output register
  logic                           ov_r, ov_nxt;
  ascs_pkg::word_t                oa_r, oa_nxt;
  ascs_pkg::word_t                ob_r, ob_nxt;
  ascs_pkg::word_t                opc_r, opc_nxt;
  ascs_pkg::word_t                osp_r, osp_nxt;
  logic [ascs_pkg::STAT_W-1:0]    ostat_r, ostat_nxt;
  ascs_pkg::word_t                ord_r, ord_nxt;

  // RAM port
  logic                           ram_we;
  logic [AW-1:0]                  ram_addr;
  ascs_pkg::word_t                ram_wdata;
  ascs_pkg::word_t                ram_rdata;

  // Decode of the fetched word
  logic [ascs_pkg::OPC_W-1:0]     opc;
  ascs_pkg::word_t                operand;
  ascs_pkg::word_t                base;
  ascs_pkg::word_t                daddr;
  logic                           d_ok;
  logic                           is_mem_op;
  ascs_pkg::word_t                pc_inc;
  ascs_pkg::word_t                pc_tgt;
  logic                           big_shift;
  logic                           pc_ok;
  ascs_pkg::word_t                in_addr32;
  logic                           in_ok;
  logic                           slot_free;
  logic                           in_ready;
  logic                           accept;

  ascs_ram #(
    .WIDTH (ascs_pkg::WORD_W),
    .DEPTH (MEM_WORDS)
  ) u_word_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // The instruction word sits on the RAM output during S_FETCH
  assign opc       = ram_rdata[ascs_pkg::OPC_W-1:0];
  assign operand   = {{(ascs_pkg::WORD_W - ascs_pkg::OPND_W){ram_rdata[ascs_pkg::WORD_W-1]}},
                      ram_rdata[ascs_pkg::WORD_W-1:ascs_pkg::OPC_W]};
  // ldl/stl address off SP, ldnl/stnl off A
  assign base      = (opc <= ascs_pkg::OP_STL) ? sp_r : a_r;
  assign daddr     = base + operand;
  assign d_ok      = daddr < MEM_LIMIT;
  assign is_mem_op = (opc >= ascs_pkg::OP_LDL) && (opc <= ascs_pkg::OP_STNL);
  assign pc_inc    = pc_r + ascs_pkg::WORD_W'(1);
  assign pc_tgt    = pc_inc + operand;
  assign big_shift = a_r >= ascs_pkg::WORD_W'(ascs_pkg::SHIFT_LIM);
  // Unsigned compare also rejects negative PCs
  assign pc_ok     = pc_r < MEM_LIMIT;

  assign in_addr32 = {{EXT_W{1'b0}}, in_ch.address};
  assign in_ok     = in_addr32 < MEM_LIMIT;

  // Output slot frees when empty or drained this cycle
  assign slot_free = !ov_r || out_ch.ready;
  assign in_ready  = (state_r == S_IDLE) || ((state_r == S_DONE) && slot_free);
  assign accept    = in_ch.valid && in_ready;

  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = ov_r;
  assign out_ch.reg_a        = oa_r;
  assign out_ch.reg_b        = ob_r;
  assign out_ch.prog_counter = opc_r;
  assign out_ch.stack_ptr    = osp_r;
  assign out_ch.run_status   = ostat_r;
  assign out_ch.read_word    = ord_r;

  always_comb begin
    state_nxt = state_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    pc_nxt    = pc_r;
    sp_nxt    = sp_r;
    stat_nxt  = stat_r;
    rd_nxt    = rd_r;
    ldl_nxt   = ldl_r;
    clr_nxt   = clr_r;
    ov_nxt    = ov_r;
    oa_nxt    = oa_r;
    ob_nxt    = ob_r;
    opc_nxt   = opc_r;
    osp_nxt   = osp_r;
    ostat_nxt = ostat_r;
    ord_nxt   = ord_r;
    ram_we    = 1'b0;
    ram_addr  = clr_r;
    ram_wdata = '0;

    // Drop the result once taken
    if (ov_r && out_ch.ready) begin
      ov_nxt = 1'b0;
    end

    // Retire: hand the architectural state to the output register
    if ((state_r == S_DONE) && slot_free) begin
      ov_nxt    = 1'b1;
      oa_nxt    = a_r;
      ob_nxt    = b_r;
      opc_nxt   = pc_r;
      osp_nxt   = sp_r;
      ostat_nxt = stat_r;
      ord_nxt   = rd_r;
      state_nxt = S_IDLE;
    end

    case (state_r)
      S_CLEAR: begin
        // Zero the word memory, one entry a cycle
        ram_we  = 1'b1;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == LAST_ENTRY) begin
          state_nxt = S_IDLE;
        end
      end

      S_READ: begin
        rd_nxt    = ram_rdata;
        state_nxt = S_DONE;
      end

      S_FETCH: begin
        state_nxt = S_DONE;
        if (opc > ascs_pkg::OP_HALT) begin
          stat_nxt = ascs_pkg::STAT_BADOP;
        end else if (is_mem_op && !d_ok) begin
          // Range fault comes before any register or memory change
          stat_nxt = ascs_pkg::STAT_RANGE;
        end else begin
          pc_nxt   = pc_inc;
          ram_addr = daddr[AW-1:0];
          case (opc)
            ascs_pkg::OP_LDC: begin
              b_nxt = a_r;
              a_nxt = operand;
            end
            ascs_pkg::OP_ADC:  a_nxt = a_r + operand;
            ascs_pkg::OP_LDL: begin
              ldl_nxt   = 1'b1;
              state_nxt = S_DATA;
            end
            ascs_pkg::OP_STL: begin
              ram_we    = 1'b1;
              ram_wdata = a_r;
              a_nxt     = b_r;
            end
            ascs_pkg::OP_LDNL: begin
              ldl_nxt   = 1'b0;
              state_nxt = S_DATA;
            end
            ascs_pkg::OP_STNL: begin
              ram_we    = 1'b1;
              ram_wdata = b_r;
            end
            ascs_pkg::OP_ADD:  a_nxt = b_r + a_r;
            ascs_pkg::OP_SUB:  a_nxt = b_r - a_r;
            ascs_pkg::OP_SHL:  a_nxt = big_shift ? '0 : (b_r << a_r[ascs_pkg::SHAMT_W-1:0]);
            ascs_pkg::OP_SHR:  a_nxt = big_shift ? '0 : (b_r >> a_r[ascs_pkg::SHAMT_W-1:0]);
            ascs_pkg::OP_ADJ:  sp_nxt = sp_r + operand;
            ascs_pkg::OP_A2SP: begin
              sp_nxt = a_r;
              a_nxt  = b_r;
            end
            ascs_pkg::OP_SP2A: begin
              b_nxt = a_r;
              a_nxt = sp_r;
            end
            ascs_pkg::OP_CALL: begin
              b_nxt  = a_r;
              a_nxt  = pc_inc;
              pc_nxt = pc_tgt;
            end
            ascs_pkg::OP_RET: begin
              pc_nxt = a_r;
              a_nxt  = b_r;
            end
            ascs_pkg::OP_BRZ: begin
              if (a_r == '0) begin
                pc_nxt = pc_tgt;
              end
            end
            ascs_pkg::OP_BRLZ: begin
              if (a_r[ascs_pkg::WORD_W-1]) begin
                pc_nxt = pc_tgt;
              end
            end
            ascs_pkg::OP_BR:   pc_nxt = pc_tgt;
            default: begin
              // HALT is the only code left here
              stat_nxt = ascs_pkg::STAT_HALT;
            end
          endcase
        end
      end

      S_DATA: begin
        a_nxt = ram_rdata;
        if (ldl_r) begin
          b_nxt = a_r;
        end
        state_nxt = S_DONE;
      end

      default: begin
        // S_IDLE and S_DONE take new transactions
      end
    endcase

    if (accept) begin
      rd_nxt    = '0;
      state_nxt = S_DONE;
      case (in_ch.cmd)
        ascs_pkg::CMD_LOAD: begin
          ram_we    = in_ok;
          ram_addr  = in_addr32[AW-1:0];
          ram_wdata = in_ch.data;
        end
        ascs_pkg::CMD_READ: begin
          ram_addr = in_addr32[AW-1:0];
          if (in_ok) begin
            state_nxt = S_READ;
          end
        end
        ascs_pkg::CMD_EXEC: begin
          ram_addr = pc_r[AW-1:0];
          if (stat_r != ascs_pkg::STAT_RUN) begin
            // Stopped: retire with no change
          end else if (!pc_ok) begin
            stat_nxt = ascs_pkg::STAT_RANGE;
          end else begin
            state_nxt = S_FETCH;
          end
        end
        default: begin
          // Unused command: retire with no change
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      a_r     <= '0;
      b_r     <= '0;
      pc_r    <= '0;
      sp_r    <= '0;
      stat_r  <= ascs_pkg::STAT_RUN;
      clr_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      a_r     <= a_nxt;
      b_r     <= b_nxt;
      pc_r    <= pc_nxt;
      sp_r    <= sp_nxt;
      stat_r  <= stat_nxt;
      clr_r   <= clr_nxt;
      ov_r    <= ov_nxt;
    end
    rd_r    <= rd_nxt;
    ldl_r   <= ldl_nxt;
    oa_r    <= oa_nxt;
    ob_r    <= ob_nxt;
    opc_r   <= opc_nxt;
    osp_r   <= osp_nxt;
    ostat_r <= ostat_nxt;
    ord_r   <= ord_nxt;
  end

endmodule

`default_nettype wire

// File: sv/ascs_checker.sv
// ----------------------------------------------------------------------------
// ascs_checker
// Port-level checks of the processor step block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ascs_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [ascs_pkg::WORD_W-1:0]       reg_a,
  input  logic signed [ascs_pkg::WORD_W-1:0] prog_counter,
  input  logic [ascs_pkg::STAT_W-1:0]       run_status,
  input  logic [ascs_pkg::WORD_W-1:0]       read_word
);

  logic                          in_acc;
  logic                          out_acc;
  logic [1:0]                    pend_r;
  logic                          stopped_r;
  logic [ascs_pkg::STAT_W-1:0]   last_stat_r;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Track transactions in flight and the last delivered stop code
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      stopped_r   <= 1'b0;
      last_stat_r <= ascs_pkg::STAT_RUN;
    end else begin
      pend_r <= pend_r + {1'b0, in_acc} - {1'b0, out_acc};
      if (out_acc && (run_status != ascs_pkg::STAT_RUN)) begin
        stopped_r   <= 1'b1;
        last_stat_r <= run_status;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before it was taken");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(reg_a) && $stable(prog_counter)
                                && $stable(run_status) && $stable(read_word))
    else $error("stalled result changed");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result without an accepted item");

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("more than two items in flight");

  a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && stopped_r |-> run_status == last_stat_r)
    else $error("stop code changed without reset");

endmodule

bind accumulator_stack_cpu_step ascs_checker u_ascs_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .reg_a        (out_ch.reg_a),
  .prog_counter (out_ch.prog_counter),
  .run_status   (out_ch.run_status),
  .read_word    (out_ch.read_word)
);

`default_nettype wire
